// ===== rtl/core/dsa_pkg.sv =====
// shared types, constants and codes of the descriptor slot allocator
`timescale 1ns / 1ps
`default_nettype none

package dsa_pkg;

	// heap geometry
	localparam int MAX_SLOTS = 1024;
	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

	// register and field widths
	localparam int BASE_W     = 64;
	localparam int STRIDE_W   = 13;
	localparam int SCOUNT_W   = 11;
	localparam int REL_W      = 10;
	localparam int SIDX_W     = 10;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int PROD_W     = IDX_W + STRIDE_W;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd2;

	// register reset values
	localparam logic [BASE_W-1:0]   HEAP_BASE_RST   = '0;
	localparam logic [STRIDE_W-1:0] SLOT_STRIDE_RST = 13'd32;
	localparam logic [SCOUNT_W-1:0] SLOT_COUNT_RST  = 11'd1024;

	// request actions
	localparam logic ACT_ALLOCATE = 1'b0;
	localparam logic ACT_RELEASE  = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_ALLOCATED = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RELEASED  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_REJECTED  = 2'd3;

	// decision of the queue controller for one request
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                from_queue;
		logic [IDX_W-1:0]    hw_index;
	} dsa_grant_t;

	// free queue memory access
	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} dsa_ram_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/dsa_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module dsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/dsa_ctrl.sv =====
// free queue pointers, high-water counter and per-request decision
`timescale 1ns / 1ps
`default_nettype none

module dsa_ctrl (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           req,
	input  wire logic                           action,
	input  wire logic [dsa_pkg::REL_W-1:0]      release_index,
	input  wire logic [dsa_pkg::SCOUNT_W-1:0]   slot_count,
	output dsa_pkg::dsa_ram_req_t               ram_req,
	output logic                                valid_s1,
	output dsa_pkg::dsa_grant_t                 grant_s1
);

	import dsa_pkg::*;

	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] hw_q;

	logic [CNT_W-1:0] eff_count;
	logic [IDX_W-1:0] head_next;
	logic [IDX_W-1:0] tail_next;
	logic             queue_empty;
	logic             queue_full;
	logic             rel_bad;
	dsa_grant_t       grant;

	// slot count saturates at the heap size
	assign eff_count = (32'(slot_count) > 32'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS)
	                                                      : CNT_W'(slot_count);

	// pointer wrap
	assign head_next = (head_q == IDX_W'(MAX_SLOTS - 1)) ? '0 : head_q + 1'b1;
	assign tail_next = (tail_q == IDX_W'(MAX_SLOTS - 1)) ? '0 : tail_q + 1'b1;

	assign queue_empty = (fill_q == '0);
	assign queue_full  = (fill_q == CNT_W'(MAX_SLOTS));
	assign rel_bad     = (32'(release_index) >= 32'(eff_count)) || queue_full;

	// decision and memory access
	always_comb begin
		grant   = '{status: ST_FULL, from_queue: 1'b0, hw_index: '0};
		ram_req = '{we: 1'b0, waddr: tail_q, wdata: IDX_W'(release_index),
		            re: 1'b0, raddr: head_q};
		if (action == ACT_ALLOCATE) begin
			if (!queue_empty) begin
				grant.status     = ST_ALLOCATED;
				grant.from_queue = 1'b1;
				ram_req.re       = req;
			end else if (hw_q < eff_count) begin
				grant.status   = ST_ALLOCATED;
				grant.hw_index = hw_q[IDX_W-1:0];
			end
		end else begin
			if (rel_bad) begin
				grant.status = ST_REJECTED;
			end else begin
				grant.status = ST_RELEASED;
				ram_req.we   = req;
			end
		end
	end

	// queue and counter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
			hw_q   <= '0;
		end else if (req) begin
			if (action == ACT_ALLOCATE) begin
				if (!queue_empty) begin
					head_q <= head_next;
					fill_q <= fill_q - 1'b1;
				end else if (hw_q < eff_count) begin
					hw_q <= hw_q + 1'b1;
				end
			end else if (!rel_bad) begin
				tail_q <= tail_next;
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// decision stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			grant_s1 <= grant;
		end
	end

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_SLOTS))
		else $error("free queue fill above heap size");

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CNT_W'(MAX_SLOTS))
		else $error("high-water counter above heap size");

	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("queue read and write in one request");

endmodule

`default_nettype wire

// ===== rtl/core/dsa_handle.sv =====
// index select, stride multiply, base add and output register
`timescale 1ns / 1ps
`default_nettype none

module dsa_handle (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           valid_s1,
	input  dsa_pkg::dsa_grant_t                 grant_s1,
	input  wire logic [dsa_pkg::IDX_W-1:0]      ram_rdata,
	input  wire logic [dsa_pkg::BASE_W-1:0]     heap_base,
	input  wire logic [dsa_pkg::STRIDE_W-1:0]   slot_stride,
	input  wire logic                           out_stall,
	output logic                                out_valid,
	output logic      [dsa_pkg::STATUS_W-1:0]   status,
	output logic      [dsa_pkg::SIDX_W-1:0]     slot_index,
	output logic      [dsa_pkg::BASE_W-1:0]     slot_handle
);

	import dsa_pkg::*;

	logic                valid_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [IDX_W-1:0]    index_s2;
	logic [PROD_W-1:0]   prod_s2;

	logic [IDX_W-1:0]    index_sel;
	logic                granted;

	// queued index comes from the memory, fresh one from the counter
	assign granted   = (grant_s1.status == ST_ALLOCATED);
	assign index_sel = !granted           ? '0 :
	                   grant_s1.from_queue ? ram_rdata : grant_s1.hw_index;

	// multiply stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_s2 <= grant_s1.status;
			index_s2  <= index_sel;
			prod_s2   <= PROD_W'(index_sel) * PROD_W'(slot_stride);
		end
	end

	// output register, held while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (valid_s2) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			status     <= status_s2;
			slot_index <= SIDX_W'(index_s2);
			slot_handle <= (status_s2 == ST_ALLOCATED) ? heap_base + BASE_W'(prod_s2)
			                                           : '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/descriptor_slot_allocator.sv =====
// descriptor slot allocator top level: config registers, queue memory, control
// a request passes the decision register, where the queue is read, the multiply register
// and the output register, where the base is added; only one request is in flight, the
// next is taken as the result is taken
// reset: queue empty, high-water counter zero, registers at their defaults;
// the free queue memory is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module descriptor_slot_allocator (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           action,
	input  wire logic [dsa_pkg::REL_W-1:0]      release_index,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [dsa_pkg::STATUS_W-1:0]   status,
	output logic      [dsa_pkg::SIDX_W-1:0]     slot_index,
	output logic      [dsa_pkg::BASE_W-1:0]     slot_handle
);

	import dsa_pkg::*;

	logic [BASE_W-1:0]   heap_base_q;
	logic [STRIDE_W-1:0] slot_stride_q;
	logic [SCOUNT_W-1:0] slot_count_q;

	logic         busy_q;
	logic         req;
	logic         out_take;
	dsa_ram_req_t ram_req;
	logic [IDX_W-1:0] ram_rdata;
	logic         valid_s1;
	dsa_grant_t   grant_s1;
	logic         valid_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q   <= HEAP_BASE_RST;
			slot_stride_q <= SLOT_STRIDE_RST;
			slot_count_q  <= SLOT_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEAP_BASE:   heap_base_q   <= cfg_data;
				REG_SLOT_STRIDE: slot_stride_q <= cfg_data[STRIDE_W-1:0];
				REG_SLOT_COUNT:  slot_count_q  <= cfg_data[SCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// one request in flight
	assign out_take = out_valid && !out_stall;
	assign in_stall = busy_q && !out_take;
	assign req      = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req) begin
			busy_q <= 1'b1;
		end else if (out_take) begin
			busy_q <= 1'b0;
		end
	end

	// free queue memory
	dsa_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_SLOTS)
	) u_queue_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	// queue control
	dsa_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req),
		.action        (action),
		.release_index (release_index),
		.slot_count    (slot_count_q),
		.ram_req       (ram_req),
		.valid_s1      (valid_s1),
		.grant_s1      (grant_s1)
	);

	// handle computation and result register
	dsa_handle u_handle (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.grant_s1    (grant_s1),
		.ram_rdata   (ram_rdata),
		.heap_base   (heap_base_q),
		.slot_stride (slot_stride_q),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.status      (status),
		.slot_index  (slot_index),
		.slot_handle (slot_handle)
	);

	// stage-two valid recreated locally for the flight check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// checks
	a_single_flight: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({valid_s1, valid_s2, out_valid}) <= 1)
		else $error("more than one request in flight");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req |=> busy_q && valid_s1)
		else $error("accepted request not tracked");

	a_result_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> busy_q)
		else $error("result without request in flight");

endmodule

`default_nettype wire

// ===== test/slot_grant_checker.sv =====
// checker for the slot allocator: tracks heap state, forecasts grants, compares results
`timescale 1ns / 1ps

module slot_grant_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsa_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           action,
	input  logic [dsa_pkg::REL_W-1:0]      release_index,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [dsa_pkg::STATUS_W-1:0]   status,
	input  logic [dsa_pkg::SIDX_W-1:0]     slot_index,
	input  logic [dsa_pkg::BASE_W-1:0]     slot_handle,
	output int                             mismatches,
	output int                             backlog
);
	import dsa_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SIDX_W-1:0]   index;
		logic [BASE_W-1:0]   handle;
	} grant_t;

	// register copies
	logic [BASE_W-1:0]   base_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [SCOUNT_W-1:0] count_q;

	// free ring and fresh-index counter
	logic [IDX_W-1:0] free_ring [MAX_SLOTS];
	logic [IDX_W-1:0] ring_rd;
	logic [IDX_W-1:0] ring_wr;
	logic [CNT_W-1:0] ring_fill;
	logic [CNT_W-1:0] next_fresh;

	grant_t owed_grants [$];
	grant_t want;
	int     fault_total = 0;

	assign mismatches = fault_total;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] exp_val);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
		fault_total++;
	endtask

	// work out the result of one request and advance the heap state
	task automatic forecast_grant(input logic act, input logic [REL_W-1:0] rel);
		logic [CNT_W-1:0] limit;
		grant_t g;
		limit = (int'(count_q) > MAX_SLOTS) ? CNT_W'(MAX_SLOTS) : CNT_W'(count_q);
		g = '0;
		if (act == ACT_ALLOCATE) begin
			if (ring_fill != 0) begin
				// oldest released index first, no bound check against the count
				g.status  = ST_ALLOCATED;
				g.index   = free_ring[ring_rd];
				ring_rd   = (int'(ring_rd) == MAX_SLOTS - 1) ? '0 : ring_rd + 1'b1;
				ring_fill = ring_fill - 1'b1;
			end else if (next_fresh < limit) begin
				g.status   = ST_ALLOCATED;
				g.index    = SIDX_W'(next_fresh);
				next_fresh = next_fresh + 1'b1;
			end else begin
				g.status = ST_FULL;
			end
			if (g.status == ST_ALLOCATED)
				g.handle = base_q + BASE_W'(g.index) * BASE_W'(stride_q);
		end else if (CNT_W'(rel) >= limit || int'(ring_fill) >= MAX_SLOTS) begin
			g.status = ST_REJECTED;
		end else begin
			free_ring[ring_wr] = rel;
			ring_wr   = (int'(ring_wr) == MAX_SLOTS - 1) ? '0 : ring_wr + 1'b1;
			ring_fill = ring_fill + 1'b1;
			g.status  = ST_RELEASED;
		end
		owed_grants.push_back(g);
	endtask

	// results are checked before new requests are forecast within one edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     = HEAP_BASE_RST;
			stride_q   = SLOT_STRIDE_RST;
			count_q    = SLOT_COUNT_RST;
			ring_rd    = '0;
			ring_wr    = '0;
			ring_fill  = '0;
			next_fresh = '0;
			owed_grants.delete();
			backlog <= 0;
		end else begin
			// compare an accepted result with the oldest forecast
			if (out_valid && !out_stall) begin
				if (owed_grants.size() == 0) begin
					report_mismatch("unrequested result, status", 64'(status), '0);
				end else begin
					want = owed_grants.pop_front();
					if (status !== want.status)
						report_mismatch("status", 64'(status), 64'(want.status));
					if (slot_index !== want.index)
						report_mismatch("slot_index", 64'(slot_index), 64'(want.index));
					if (slot_handle !== want.handle)
						report_mismatch("slot_handle", slot_handle, want.handle);
				end
			end

			// register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_HEAP_BASE:   base_q   = cfg_data;
					REG_SLOT_STRIDE: stride_q = cfg_data[STRIDE_W-1:0];
					REG_SLOT_COUNT:  count_q  = cfg_data[SCOUNT_W-1:0];
					default: ;
				endcase
			end

			// accepted request
			if (in_valid && !in_stall)
				forecast_grant(action, release_index);

			backlog <= owed_grants.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// testbench top: clock, reset, register and request stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
	import dsa_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  action;
	logic [REL_W-1:0]      release_index;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [SIDX_W-1:0]     slot_index;
	logic [BASE_W-1:0]     slot_handle;

	int fault_count;
	int waiting_results;
	int stall_left = 0;
	bit calm = 1'b0;

	descriptor_slot_allocator dut (.*);

	slot_grant_checker u_checker (
		.*,
		.mismatches(fault_count),
		.backlog(waiting_results)
	);

	always #1 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 5);
	endfunction

	// release index mostly below or just above the slot count, sometimes anywhere
	function automatic logic [REL_W-1:0] pick_release(input int count);
		if ($urandom_range(4) == 0)
			return REL_W'($urandom_range(1023));
		return REL_W'($urandom_range((count > 1021) ? 1023 : count + 2));
	endfunction

	// result side back-pressure
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	// one request, held until taken; valid stays high when no gap follows
	task automatic send_request(input logic act, input logic [REL_W-1:0] rel);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		release_index <= rel;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	// stop sending and wait for every outstanding result plus a short tail
	task automatic settle();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (waiting_results != 0);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers back to back
	task automatic program_heap(input logic [BASE_W-1:0] base, input int stride,
			input int count);
		cfg_we    <= 1'b1;
		cfg_index <= REG_HEAP_BASE;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= REG_SLOT_STRIDE;
		cfg_data  <= CFG_DATA_W'(stride);
		@(posedge clk);
		cfg_index <= REG_SLOT_COUNT;
		cfg_data  <= CFG_DATA_W'(count);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// run limit
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		int count;
		int sub;
		int n;

		in_valid      <= 1'b0;
		action        <= ACT_ALLOCATE;
		release_index <= '0;
		cfg_we        <= 1'b0;
		cfg_index     <= REG_HEAP_BASE;
		cfg_data      <= '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults: fresh grants, duplicate and never-granted releases, reuse order
		send_request(ACT_ALLOCATE, '1);
		send_request(ACT_ALLOCATE, '0);
		send_request(ACT_ALLOCATE, REL_W'($urandom));
		send_request(ACT_RELEASE, 10'd1);
		send_request(ACT_RELEASE, 10'd1);
		send_request(ACT_RELEASE, 10'd1023);
		repeat (4) send_request(ACT_ALLOCATE, REL_W'($urandom));

		// zero slots: heap full and every release out of range
		settle();
		program_heap('1, 4096, 0);
		send_request(ACT_ALLOCATE, '0);
		send_request(ACT_RELEASE, '0);

		// count above the slot limit saturates, stride at its maximum, handle wraps
		settle();
		program_heap('1, 8191, 2047);
		send_request(ACT_ALLOCATE, '0);
		send_request(ACT_RELEASE, 10'd1023);
		send_request(ACT_RELEASE, 10'd1000);

		// zero stride, count lowered below queued indices, then fresh grants run out
		settle();
		program_heap(64'h8000_0000_0000_0000, 0, 10);
		repeat (8) send_request(ACT_ALLOCATE, REL_W'($urandom));
		send_request(ACT_RELEASE, 10'd10);
		send_request(ACT_RELEASE, 10'd9);

		// single slot, unit stride
		settle();
		program_heap('0, 1, 1);
		send_request(ACT_ALLOCATE, '1);
		send_request(ACT_ALLOCATE, '1);
		send_request(ACT_RELEASE, 10'd0);
		send_request(ACT_RELEASE, 10'd1);

		// small heaps with heavy reuse and frequent full
		for (sub = 0; sub < 3; sub++) begin
			settle();
			calm = (sub == 1);
			case (sub)
				0: count = 1;
				1: count = $urandom_range(16, 2);
				default: count = $urandom_range(64, 17);
			endcase
			program_heap({$urandom, $urandom}, $urandom_range(4096, 1), count);
			repeat (100) begin
				// now and then hold off until the allocator has drained
				if ($urandom_range(49) == 0)
					settle();
				if ($urandom_range(1))
					send_request(ACT_RELEASE, pick_release(count));
				else
					send_request(ACT_ALLOCATE, REL_W'($urandom));
			end
		end

		// full heap, releases only: fill the free queue past overflow
		settle();
		calm = 1'b0;
		program_heap({$urandom, $urandom}, $urandom_range(4096, 1), 1024);
		repeat (1030) send_request(ACT_RELEASE, REL_W'($urandom));

		// drain part of the queue with mostly allocations
		settle();
		program_heap({$urandom, $urandom}, $urandom_range(8191), 2047);
		for (n = 0; n < 90; n++) begin
			calm = (n % 30) < 10;
			if ($urandom_range(99) < 94)
				send_request(ACT_ALLOCATE, REL_W'($urandom));
			else
				send_request(ACT_RELEASE, pick_release(1024));
		end

		settle();
		if (fault_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
